// ===== rtl/longest_increasing_subsequence_assert.svh =====
// Assertion macros for the longest increasing subsequence block
`ifndef LONGEST_INCREASING_SUBSEQUENCE_ASSERT_SVH
`define LONGEST_INCREASING_SUBSEQUENCE_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define LIS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lis: same-cycle check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define LIS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lis: next-cycle check failed");

`endif

// ===== rtl/lis_pkg.sv =====
// Shared constants and controller/datapath handshake types
`default_nettype none
package lis_pkg;

	localparam int MAX_ELEMENTS = 64;
	localparam int VALUE_WIDTH  = 32;
	localparam int IDX_W        = $clog2(MAX_ELEMENTS);
	localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);

	typedef struct packed {
		logic load;
		logic row_rd;
		logic latch;
		logic scan;
		logic row_wr;
		logic trace_rd;
		logic trace_wr;
		logic emit_rd;
		logic emit_elem;
		logic emit_out;
	} lis_cmd_t;

	typedef struct packed {
		logic eos_accepted;
		logic rows_done;
		logic scan_done;
		logic trace_stop;
		logic out_free;
		logic emit_last;
	} lis_sts_t;

endpackage
`default_nettype wire

// ===== rtl/lis_if.sv =====
// Valid/ready channel interfaces for input and result words
`default_nettype none
interface lis_in_if;
	import lis_pkg::*;
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] sample_value;
	logic                          end_of_sequence;

	modport source (output valid, output sample_value, output end_of_sequence, input ready);
	modport sink (input valid, input sample_value, input end_of_sequence, output ready);
endinterface

interface lis_out_if;
	import lis_pkg::*;
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] chosen_value;
	logic        [CNT_W-1:0]       subsequence_length;
	logic                          final_result;
	logic                          capacity_exceeded;

	modport source (output valid, output chosen_value, output subsequence_length,
		output final_result, output capacity_exceeded, input ready);
	modport sink (input valid, input chosen_value, input subsequence_length,
		input final_result, input capacity_exceeded, output ready);
endinterface
`default_nettype wire

// ===== rtl/longest_increasing_subsequence.sv =====
// On the closing word the dynamic program runs, one compare per cycle against the earlier
// stored elements. Trace back then reads and writes each subsequence element, and emit
// reads the path entry and element of each result word, then waits for a free output register.
// Throughput: one word per cycle while loading; a whole sequence is processed at a time.
// Reset: arst_n clears counters, flags and the sequencer; memories are not cleared.
`default_nettype none
module longest_increasing_subsequence (
	input wire logic  clk,
	input wire logic  arst_n,
	lis_in_if.sink    din,
	lis_out_if.source dout
);
	import lis_pkg::*;

	lis_cmd_t cmd;
	lis_sts_t sts;

	lis_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	lis_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.din    (din),
		.dout   (dout)
	);

endmodule
`default_nettype wire

// ===== rtl/lis_ctrl.sv =====
// Sequencer for load, dynamic program, trace back and emit phases
`default_nettype none
module lis_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lis_pkg::lis_sts_t sts,
	output lis_pkg::lis_cmd_t      cmd
);
	import lis_pkg::*;

	typedef enum logic [9:0] {
		S_LOAD      = 10'b00_0000_0001,
		S_ROW       = 10'b00_0000_0010,
		S_LATCH     = 10'b00_0000_0100,
		S_SCAN      = 10'b00_0000_1000,
		S_WRITE     = 10'b00_0001_0000,
		S_TRACE_RD  = 10'b00_0010_0000,
		S_TRACE_WR  = 10'b00_0100_0000,
		S_EMIT_RD   = 10'b00_1000_0000,
		S_EMIT_ELEM = 10'b01_0000_0000,
		S_EMIT_OUT  = 10'b10_0000_0000
	} lis_state_t;

	lis_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_LOAD: begin
				cmd.load = 1'b1;
				if (sts.eos_accepted) state_d = S_ROW;
			end
			S_ROW: begin
				cmd.row_rd = 1'b1;
				state_d    = sts.rows_done ? S_TRACE_RD : S_LATCH;
			end
			S_LATCH: begin
				cmd.latch = 1'b1;
				state_d   = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) state_d = S_WRITE;
			end
			S_WRITE: begin
				cmd.row_wr = 1'b1;
				state_d    = S_ROW;
			end
			S_TRACE_RD: begin
				cmd.trace_rd = 1'b1;
				state_d      = S_TRACE_WR;
			end
			S_TRACE_WR: begin
				cmd.trace_wr = 1'b1;
				state_d      = sts.trace_stop ? S_EMIT_RD : S_TRACE_RD;
			end
			S_EMIT_RD: begin
				cmd.emit_rd = 1'b1;
				state_d     = S_EMIT_ELEM;
			end
			S_EMIT_ELEM: begin
				cmd.emit_elem = 1'b1;
				state_d       = S_EMIT_OUT;
			end
			S_EMIT_OUT: begin
				cmd.emit_out = 1'b1;
				// wait for a free output register, then step or finish
				if (sts.out_free) state_d = sts.emit_last ? S_LOAD : S_EMIT_RD;
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/lis_dp.sv =====
// Element, length, predecessor and path memories with counters and output register
`default_nettype none
module lis_dp (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lis_pkg::lis_cmd_t cmd,
	output lis_pkg::lis_sts_t      sts,
	lis_in_if.sink                 din,
	lis_out_if.source              dout
);
	import lis_pkg::*;

	logic [VALUE_WIDTH-1:0] elem_mem [MAX_ELEMENTS];
	logic [CNT_W-1:0]       len_mem  [MAX_ELEMENTS];
	logic [IDX_W-1:0]       pred_mem [MAX_ELEMENTS];
	logic [IDX_W-1:0]       path_mem [MAX_ELEMENTS];

	logic signed [VALUE_WIDTH-1:0] elem_rd_q;
	logic [CNT_W-1:0]              len_rd_q;
	logic [IDX_W-1:0]              pred_rd_q;
	logic [IDX_W-1:0]              path_rd_q;

	logic [CNT_W-1:0] count_q, i_q, p_q, best_q, tlen_q, e_q;
	logic             ovf_q, valid_s1, out_valid_q;
	logic [IDX_W-1:0] last_q, k_q, p_s1;

	logic signed [VALUE_WIDTH-1:0] cur_val_q;
	logic [CNT_W-1:0]              cur_len_q;
	logic [IDX_W-1:0]              cur_pred_q;

	logic signed [VALUE_WIDTH-1:0] out_val_q;
	logic [CNT_W-1:0]              out_len_q;
	logic                          out_fin_q, out_cap_q;

	logic             accept, store_ok, out_load, better;
	logic [IDX_W-1:0] rd_addr, elem_addr, path_addr;
	logic [CNT_W-1:0] e_dec, tlen_inc;

	assign accept   = din.valid & cmd.load;
	assign store_ok = count_q < CNT_W'(MAX_ELEMENTS);
	assign e_dec    = e_q - CNT_W'(1);
	assign tlen_inc = tlen_q + CNT_W'(1);

	assign sts.eos_accepted = accept & din.end_of_sequence;
	assign sts.rows_done    = i_q == count_q;
	assign sts.scan_done    = p_q == i_q;
	assign sts.trace_stop   = (pred_rd_q == k_q) || (tlen_inc >= CNT_W'(MAX_ELEMENTS));
	assign sts.out_free     = !out_valid_q || dout.ready;
	assign sts.emit_last    = e_q == CNT_W'(1);

	assign out_load = cmd.emit_out & sts.out_free;
	assign better   = valid_s1 && (elem_rd_q < cur_val_q) && (len_rd_q >= cur_len_q);

	always_comb begin
		case (1'b1)
			cmd.row_rd:   rd_addr = i_q[IDX_W-1:0];
			cmd.trace_rd: rd_addr = k_q;
			default:      rd_addr = p_q[IDX_W-1:0];
		endcase
	end

	// keep reading the path element while the result word waits
	assign elem_addr = (cmd.emit_elem | cmd.emit_out) ? path_rd_q : rd_addr;
	assign path_addr = e_dec[IDX_W-1:0];

	// memories: one write port, registered reads
	always_ff @(posedge clk) begin
		if (accept && store_ok) elem_mem[count_q[IDX_W-1:0]] <= din.sample_value;
		if (cmd.row_wr) begin
			len_mem[i_q[IDX_W-1:0]]  <= cur_len_q;
			pred_mem[i_q[IDX_W-1:0]] <= cur_pred_q;
		end
		if (cmd.trace_wr) path_mem[tlen_q[IDX_W-1:0]] <= k_q;
		elem_rd_q <= elem_mem[elem_addr];
		len_rd_q  <= len_mem[rd_addr];
		pred_rd_q <= pred_mem[rd_addr];
		if (cmd.emit_rd) path_rd_q <= path_mem[path_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ovf_q       <= 1'b0;
			i_q         <= '0;
			p_q         <= '0;
			valid_s1    <= 1'b0;
			best_q      <= '0;
			last_q      <= '0;
			k_q         <= '0;
			tlen_q      <= '0;
			e_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				if (store_ok) count_q <= count_q + CNT_W'(1);
				else ovf_q <= 1'b1;
				if (din.end_of_sequence) begin
					i_q    <= '0;
					best_q <= '0;
					last_q <= '0;
				end
			end
			if (cmd.row_rd && sts.rows_done) begin
				k_q    <= last_q;
				tlen_q <= '0;
			end
			if (cmd.latch) p_q <= '0;
			if (cmd.scan && !sts.scan_done) p_q <= p_q + CNT_W'(1);
			valid_s1 <= cmd.scan && !sts.scan_done;
			if (cmd.row_wr) begin
				i_q <= i_q + CNT_W'(1);
				// strict compare keeps the earliest end position on a tie
				if (cur_len_q > best_q) begin
					best_q <= cur_len_q;
					last_q <= i_q[IDX_W-1:0];
				end
			end
			if (cmd.trace_wr) begin
				tlen_q <= tlen_inc;
				k_q    <= pred_rd_q;
				e_q    <= tlen_inc;
			end
			if (dout.ready) out_valid_q <= 1'b0;
			if (out_load) begin
				out_valid_q <= 1'b1;
				e_q         <= e_dec;
				if (sts.emit_last) begin
					count_q <= '0;
					ovf_q   <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		p_s1 <= p_q[IDX_W-1:0];
		if (cmd.latch) begin
			cur_val_q  <= elem_rd_q;
			cur_len_q  <= CNT_W'(1);
			cur_pred_q <= i_q[IDX_W-1:0];
		end else if (better) begin
			// take the earliest predecessor that strictly lengthens the run
			cur_len_q  <= len_rd_q + CNT_W'(1);
			cur_pred_q <= p_s1;
		end
		if (out_load) begin
			out_val_q <= elem_rd_q;
			out_len_q <= tlen_q;
			out_fin_q <= sts.emit_last;
			out_cap_q <= ovf_q;
		end
	end

	assign din.ready                = cmd.load;
	assign dout.valid               = out_valid_q;
	assign dout.chosen_value        = out_val_q;
	assign dout.subsequence_length  = out_len_q;
	assign dout.final_result        = out_fin_q;
	assign dout.capacity_exceeded   = out_cap_q;

endmodule
`default_nettype wire

// ===== rtl/lis_checker.sv =====
// Port-level checks on the longest increasing subsequence block, with bind
`default_nettype none
`include "longest_increasing_subsequence_assert.svh"
module lis_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_ready,
	input wire logic                          in_eos,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic [lis_pkg::VALUE_WIDTH-1:0] out_value,
	input wire logic [lis_pkg::CNT_W-1:0]     out_length
);
	import lis_pkg::*;

	// hold a stalled result word
	`LIS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_value))
	// a word without end mark never starts output
	`LIS_ASSERT_NXT(a_no_spurious, in_valid && in_ready && !in_eos, !$rose(out_valid))
	// stop taking words once the sequence is closed
	`LIS_ASSERT_NXT(a_busy_after_eos, in_valid && in_ready && in_eos, !in_ready)
	`LIS_ASSERT_IMP(a_len_range, out_valid, (out_length != '0) && (out_length <= CNT_W'(MAX_ELEMENTS)))

endmodule

bind longest_increasing_subsequence lis_checker u_lis_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (din.valid),
	.in_ready   (din.ready),
	.in_eos     (din.end_of_sequence),
	.out_valid  (dout.valid),
	.out_ready  (dout.ready),
	.out_value  (dout.chosen_value),
	.out_length (dout.subsequence_length)
);
`default_nettype wire
